/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the checker files of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* hw/rtl/lpsd_pkg.sv */
// Package: types, widths and codes of the length-prefixed section deframer.
`timescale 1ns / 1ps

package lpsd_pkg;

  localparam int DATA_W = 8;   // one stream byte
  localparam int LEN_W  = 64;  // widest section length
  localparam int LCNT_W = 4;   // length bytes still to come (0..8)
  localparam int KIND_W = 2;
  localparam int IDX_W  = 2;   // configuration register index

  // Length byte counts announced by the three markers
  localparam logic [LCNT_W-1:0] LEN_BYTES_TWO   = 4'd2;
  localparam logic [LCNT_W-1:0] LEN_BYTES_FOUR  = 4'd4;
  localparam logic [LCNT_W-1:0] LEN_BYTES_EIGHT = 4'd8;

  // Marker reset values
  localparam logic [DATA_W-1:0] MARKER_TWO_RST   = 8'd253;
  localparam logic [DATA_W-1:0] MARKER_FOUR_RST  = 8'd254;
  localparam logic [DATA_W-1:0] MARKER_EIGHT_RST = 8'd255;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] CFG_MARKER_TWO   = 2'd0;
  localparam logic [IDX_W-1:0] CFG_MARKER_FOUR  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_MARKER_EIGHT = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_PAYLOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EMPTY     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TRUNCATED = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef struct packed {
    logic [DATA_W-1:0] two;
    logic [DATA_W-1:0] four;
    logic [DATA_W-1:0] eight;
  } markers_t;

  typedef struct packed {
    logic              emit;
    logic [DATA_W-1:0] byte_out;
    logic [KIND_W-1:0] kind;
    logic              section_last;
    logic              buffer_end;
  } result_t;

endpackage

/* hw/rtl/length_prefixed_section_deframer_top.sv */
// Length-prefixed section deframer: top level with input register and marker registers.
//
// Takes one byte per cycle (in_tlast marks the buffer's final byte) and splits the buffer
// into sections. A header byte equal to a marker register is followed by a 2-, 4- or
// 8-byte big-endian length; any other header byte is the length itself. Payload bytes
// come out with out_tlast on the last byte of a section; a zero-length section gives one
// empty-section item; a buffer that ends inside a header or payload gives one truncated
// item, after which downstream should drop that buffer's sections. Marker headers and
// length bytes give no output item. Throughput is one byte per cycle while the output
// is not stalled; each result passes the input register, then the result register. The
// loop that sets the rate is the state update of the phase and the 64-bit remaining-length
// counter. Configuration must be written only while idle; the block itself does not enforce it.
`timescale 1ns / 1ps

module length_prefixed_section_deframer_top
  import lpsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // [7:0] byte_in
  input  logic              in_tlast,   // buffer_last
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // [7:0] byte_out
  output logic              out_tlast,  // section_last
  output logic [2:0]        out_tuser,  // [1:0] kind, [2] buffer_end
  // configuration write port
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_idx,
  input  logic [DATA_W-1:0] cfg_wdata
);

  logic              in_valid_r, in_valid_nxt;
  logic [DATA_W-1:0] in_byte_r;
  logic              in_last_r;
  logic              advance;
  logic              in_acc;
  markers_t          markers_r;
  result_t           res;

  // Register item moves on when the result register can take it
  assign advance   = in_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_acc) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // Marker registers; writes to unused indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      markers_r.two   <= MARKER_TWO_RST;
      markers_r.four  <= MARKER_FOUR_RST;
      markers_r.eight <= MARKER_EIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MARKER_TWO:   markers_r.two   <= cfg_wdata;
        CFG_MARKER_FOUR:  markers_r.four  <= cfg_wdata;
        CFG_MARKER_EIGHT: markers_r.eight <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lpsd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .in_byte (in_byte_r),
    .in_last (in_last_r),
    .markers (markers_r),
    .res     (res)
  );

  lpsd_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .res        (res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

/* hw/rtl/lpsd_core.sv */
// Deframer state (phase, length byte count, remaining length) and per-item result logic.
`timescale 1ns / 1ps

module lpsd_core
  import lpsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,      // registered item is consumed this cycle
  input  logic [DATA_W-1:0] in_byte,
  input  logic              in_last,
  input  markers_t          markers,
  output result_t           res
);

  phase_t             phase_r, phase_nxt;
  logic [LCNT_W-1:0]  len_left_r, len_left_nxt;
  logic [LEN_W-1:0]   remain_r, remain_nxt;
  logic [LCNT_W-1:0]  len_left_dec;

  // Length byte count after this length byte, saturating at zero
  assign len_left_dec = (len_left_r != '0) ? (len_left_r - 4'd1) : '0;

  // Next state and result for the registered item
  always_comb begin
    phase_nxt        = phase_r;
    len_left_nxt     = len_left_r;
    remain_nxt       = remain_r;
    res              = '0;
    res.buffer_end   = in_last;
    case (phase_r)
      PH_LENGTH: begin
        remain_nxt   = {remain_r[LEN_W-DATA_W-1:0], in_byte};
        len_left_nxt = len_left_dec;
        if (len_left_dec == '0) begin
          if (remain_nxt == '0) begin
            res.emit         = 1'b1;
            res.kind         = KIND_EMPTY;
            res.section_last = 1'b1;
            phase_nxt        = PH_HEADER;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        res.emit     = 1'b1;
        res.kind     = KIND_PAYLOAD;
        res.byte_out = in_byte;
        if (remain_r[LEN_W-1:1] == '0) begin
          res.section_last = 1'b1;
          remain_nxt       = '0;
          phase_nxt        = PH_HEADER;
        end else begin
          remain_nxt = remain_r - 64'd1;
        end
      end
      default: begin
        // header byte; the unused phase code behaves the same
        phase_nxt  = PH_HEADER;
        remain_nxt = '0;
        if (in_byte == markers.two) begin
          len_left_nxt = LEN_BYTES_TWO;
          phase_nxt    = PH_LENGTH;
        end else if (in_byte == markers.four) begin
          len_left_nxt = LEN_BYTES_FOUR;
          phase_nxt    = PH_LENGTH;
        end else if (in_byte == markers.eight) begin
          len_left_nxt = LEN_BYTES_EIGHT;
          phase_nxt    = PH_LENGTH;
        end else if (in_byte == '0) begin
          res.emit         = 1'b1;
          res.kind         = KIND_EMPTY;
          res.section_last = 1'b1;
        end else begin
          remain_nxt = {{(LEN_W-DATA_W){1'b0}}, in_byte};
          phase_nxt  = PH_PAYLOAD;
        end
      end
    endcase

    // Buffer ends with a header or payload still open
    if (in_last && (phase_nxt != PH_HEADER)) begin
      res.emit         = 1'b1;
      res.kind         = KIND_TRUNCATED;
      res.byte_out     = '0;
      res.section_last = 1'b1;
      phase_nxt        = PH_HEADER;
      len_left_nxt     = '0;
      remain_nxt       = '0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      len_left_r <= '0;
      remain_r   <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      len_left_r <= len_left_nxt;
      remain_r   <= remain_nxt;
    end
  end

endmodule

/* hw/rtl/lpsd_out_reg.sv */
// Result register: holds one result item until the downstream side takes it.
`timescale 1ns / 1ps

module lpsd_out_reg
  import lpsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,       // core consumed an item this cycle
  input  result_t           res,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [DATA_W-1:0] out_tdata,
  output logic              out_tlast,
  output logic [2:0]        out_tuser
);

  logic              valid_r, valid_nxt;
  logic [DATA_W-1:0] byte_r;
  logic [KIND_W-1:0] kind_r;
  logic              sl_r;
  logic              be_r;

  // A load only happens when the register is empty or being drained
  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = res.emit;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load && res.emit) begin
      byte_r <= res.byte_out;
      kind_r <= res.kind;
      sl_r   <= res.section_last;
      be_r   <= res.buffer_end;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = byte_r;
  assign out_tlast  = sl_r;
  assign out_tuser  = {be_r, kind_r};

endmodule

/* hw/rtl/lpsd_checker.sv */
// Port-level checker for the deframer top level, with its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lpsd_checker
  import lpsd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [DATA_W-1:0] out_tdata,
  input logic              out_tlast,
  input logic [2:0]        out_tuser
);

  logic [DATA_W+3:0] out_word;

  // all result fields side by side
  assign out_word = {out_tdata, out_tuser, out_tlast};

  // stalled result holds
  `ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_word))

  // empty and truncated items carry no byte
  `ASSERT_SAME(a_nonpayload_zero, out_tvalid && (out_tuser[1:0] != KIND_PAYLOAD), out_tdata == '0)

  // empty and truncated items always close a section
  `ASSERT_SAME(a_nonpayload_last, out_tvalid && (out_tuser[1:0] != KIND_PAYLOAD), out_tlast)

  // truncation only on the buffer's final byte
  `ASSERT_SAME(a_trunc_end, out_tvalid && (out_tuser[1:0] == KIND_TRUNCATED), out_tuser[2])

endmodule

bind length_prefixed_section_deframer_top lpsd_checker u_lpsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

/* dv/length_prefixed_section_deframer_checker.sv */
// Checker for the section deframer: predicts results from accepted items and compares.
`timescale 1ns / 1ps

module length_prefixed_section_deframer_checker
  import lpsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // [7:0] byte_in
  input  logic              in_tlast,   // buffer_last
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [DATA_W-1:0] out_tdata,  // [7:0] byte_out
  input  logic              out_tlast,  // section_last
  input  logic [2:0]        out_tuser,  // [1:0] kind, [2] buffer_end
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_idx,
  input  logic [DATA_W-1:0] cfg_wdata,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [KIND_W-1:0] kind;
    logic              sec_last;
    logic              buf_end;
  } section_item_t;

  section_item_t section_q[$];

  // shadow of the marker registers and the deframer state
  markers_t          markers;
  phase_t            dfr_phase;
  logic [LCNT_W-1:0] len_left;
  logic [LEN_W-1:0]  remaining;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // advance the deframer by one byte and queue the result it gives, if any
  task automatic deframe_byte(input logic [DATA_W-1:0] b, input logic buf_last);
    section_item_t res;
    logic          emit;
    emit = 1'b0;
    res  = '0;
    case (dfr_phase)
      PH_LENGTH: begin
        remaining = {remaining[LEN_W-9:0], b};
        if (len_left != 0) len_left = len_left - 1'b1;
        if (len_left == 0) begin
          if (remaining == 0) begin
            emit         = 1'b1;
            res.kind     = KIND_EMPTY;
            res.sec_last = 1'b1;
            dfr_phase    = PH_HEADER;
          end else begin
            dfr_phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        emit     = 1'b1;
        res.kind = KIND_PAYLOAD;
        res.data = b;
        if (remaining <= 1) begin
          res.sec_last = 1'b1;
          remaining    = '0;
          dfr_phase    = PH_HEADER;
        end else begin
          remaining = remaining - 1'b1;
        end
      end
      default: begin
        // header byte: markers take priority two, four, eight
        dfr_phase = PH_HEADER;
        remaining = '0;
        if (b == markers.two) begin
          len_left  = LEN_BYTES_TWO;
          dfr_phase = PH_LENGTH;
        end else if (b == markers.four) begin
          len_left  = LEN_BYTES_FOUR;
          dfr_phase = PH_LENGTH;
        end else if (b == markers.eight) begin
          len_left  = LEN_BYTES_EIGHT;
          dfr_phase = PH_LENGTH;
        end else if (b == 0) begin
          emit         = 1'b1;
          res.kind     = KIND_EMPTY;
          res.sec_last = 1'b1;
        end else begin
          remaining = LEN_W'(b);
          dfr_phase = PH_PAYLOAD;
        end
      end
    endcase
    // buffer ends with a header or payload still open
    if (buf_last && dfr_phase != PH_HEADER) begin
      emit         = 1'b1;
      res.data     = '0;
      res.kind     = KIND_TRUNCATED;
      res.sec_last = 1'b1;
      dfr_phase    = PH_HEADER;
      len_left     = '0;
      remaining    = '0;
    end
    res.buf_end = buf_last;
    if (emit) section_q = {section_q, res};
  endtask

  task automatic report_field(input string name, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
    $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
    fail_count++;
  endtask

  always @(posedge clk) begin
    section_item_t exp_item;
    if (!rst_n) begin
      markers   = '{two: MARKER_TWO_RST, four: MARKER_FOUR_RST, eight: MARKER_EIGHT_RST};
      dfr_phase = PH_HEADER;
      len_left  = '0;
      remaining = '0;
      section_q.delete();
    end else begin
      // marker writes
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MARKER_TWO:   markers.two   = cfg_wdata;
          CFG_MARKER_FOUR:  markers.four  = cfg_wdata;
          CFG_MARKER_EIGHT: markers.eight = cfg_wdata;
          default: ;
        endcase
      end
      // accepted result against the oldest expectation
      if (out_tvalid && out_tready) begin
        if (section_q.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual data %0h kind %0d",
                   $time, out_tdata, out_tuser[1:0]);
          fail_count++;
        end else begin
          exp_item = section_q.pop_front();
          if (out_tdata !== exp_item.data)
            report_field("byte_out", exp_item.data, out_tdata);
          if (out_tuser[1:0] !== exp_item.kind)
            report_field("kind", 8'(exp_item.kind), 8'(out_tuser[1:0]));
          if (out_tlast !== exp_item.sec_last)
            report_field("section_last", 8'(exp_item.sec_last), 8'(out_tlast));
          if (out_tuser[2] !== exp_item.buf_end)
            report_field("buffer_end", 8'(exp_item.buf_end), 8'(out_tuser[2]));
        end
      end
      // accepted input item
      if (in_tvalid && in_tready) deframe_byte(in_tdata, in_tlast);
    end
    pending = section_q.size();
  end

endmodule

/* dv/length_prefixed_section_deframer_top_tb.sv */
// Testbench top for the section deframer: clock, reset, stimulus, back-pressure, verdict.
`timescale 1ns / 1ps

module length_prefixed_section_deframer_top_tb;
  import lpsd_pkg::*;

  localparam int ITEMS_PER_PHASE = 270;
  localparam int LONG_HOLD       = 400;
  localparam int IDLE_TAIL       = 6;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata;   // [7:0] byte_in
  logic              in_tlast;   // buffer_last
  logic              out_tvalid;
  logic              out_tready;
  logic [DATA_W-1:0] out_tdata;  // [7:0] byte_out
  logic              out_tlast;  // section_last
  logic [2:0]        out_tuser;  // [1:0] kind, [2] buffer_end
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_idx;
  logic [DATA_W-1:0] cfg_wdata;

  int fail_count;
  int pending;

  // stimulus state
  logic [DATA_W-1:0] frame_q[$];
  logic [DATA_W-1:0] m_two, m_four, m_eight;
  int                items_sent  = 0;
  int                burst_left  = 0;
  bit                open_section;
  bit                long_hold_req = 1'b0;

  always #4 clk = ~clk;

  length_prefixed_section_deframer_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  length_prefixed_section_deframer_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // offer one item; bursts of random length with random gaps between them
  task automatic push_item(input logic [DATA_W-1:0] b, input logic buf_last);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 16);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= buf_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_frame;
    foreach (frame_q[i]) push_item(frame_q[i], i == frame_q.size() - 1);
  endtask

  // stop offering and wait until every expected result has come
  task automatic wait_idle;
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  task automatic write_markers(input logic [7:0] two, input logic [7:0] four,
                               input logic [7:0] eight);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_MARKER_TWO;
    cfg_wdata <= two;
    @(posedge clk);
    cfg_idx   <= CFG_MARKER_FOUR;
    cfg_wdata <= four;
    @(posedge clk);
    cfg_idx   <= CFG_MARKER_EIGHT;
    cfg_wdata <= eight;
    @(posedge clk);
    cfg_we    <= 1'b0;
    m_two   = two;
    m_four  = four;
    m_eight = eight;
  endtask

  function automatic logic [63:0] pick_len(input int bits);
    logic [63:0] full;
    full = {$urandom, $urandom};
    if (bits < 64) full = full & ((64'd1 << bits) - 1);
    case ($urandom_range(0, 9))
      0:       return 64'($urandom_range(13, 40));
      1:       return full;
      default: return 64'($urandom_range(0, 12));
    endcase
  endfunction

  // header, big-endian length bytes, then payload (cut short on huge lengths)
  task automatic add_section(input logic [7:0] hdr, input int nlen, input logic [63:0] len);
    int count;
    frame_q = {frame_q, hdr};
    for (int i = nlen - 1; i >= 0; i--) frame_q = {frame_q, len[8*i +: 8]};
    count = (len > 40) ? 40 : int'(len);
    repeat (count) frame_q = {frame_q, 8'($urandom_range(0, 255))};
    if (len > 40) open_section = 1'b1;
  endtask

  task automatic build_frame;
    int          n_sec;
    logic [7:0]  v;
    bit          zero_is_marker;
    frame_q.delete();
    open_section   = 1'b0;
    zero_is_marker = (m_two == 0) || (m_four == 0) || (m_eight == 0);
    if ($urandom_range(0, 9) == 0) begin
      // noise
      repeat ($urandom_range(1, 16)) frame_q = {frame_q, 8'($urandom_range(0, 255))};
      return;
    end
    n_sec = $urandom_range(1, 4);
    for (int s = 0; s < n_sec && !open_section; s++) begin
      case ($urandom_range(0, 9))
        0: begin
          if (zero_is_marker) add_section(m_two, 2, 64'd0);
          else add_section(8'd0, 0, 64'd0);
        end
        1, 2: add_section(m_two, 2, pick_len(16));
        3:    add_section(m_four, 4, pick_len(32));
        4:    add_section(m_eight, 8, pick_len(64));
        default: begin
          v = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255))
                                          : 8'($urandom_range(1, 12));
          if (v == m_two || v == m_four || v == m_eight) add_section(m_two, 2, 64'(v));
          else add_section(v, 0, 64'(v));
        end
      endcase
    end
    // sometimes cut the buffer short
    if ($urandom_range(0, 6) == 0 && frame_q.size() > 1)
      repeat ($urandom_range(1, frame_q.size() - 1)) frame_q.delete(frame_q.size() - 1);
  endtask

  task automatic random_phase(input logic [7:0] two, input logic [7:0] four,
                              input logic [7:0] eight, input bit with_hold);
    int target;
    wait_idle();
    write_markers(two, four, eight);
    target = items_sent + ITEMS_PER_PHASE;
    if (with_hold) long_hold_req = 1'b1;
    while (items_sent < target) begin
      build_frame();
      send_frame();
      if ($urandom_range(0, 40) == 0) wait_idle();
    end
  endtask

  // receiver: stretches of full rate, random stalls and heavy stalls
  initial begin
    int mode;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(10, 80)) begin
        if (long_hold_req) begin
          long_hold_req = 1'b0;
          out_tready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
        end
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= CFG_MARKER_TWO;
    cfg_wdata <= '0;
    m_two   = MARKER_TWO_RST;
    m_four  = MARKER_FOUR_RST;
    m_eight = MARKER_EIGHT_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset markers
    // header zero, then header zero closing the buffer
    frame_q = {8'h00, 8'h00};
    send_frame();
    // direct length with alternating-bit payload bytes
    frame_q = {8'h02, 8'hAA, 8'h55};
    send_frame();
    // two-byte length of zero
    frame_q = {8'd253, 8'h00, 8'h00};
    send_frame();
    // four-byte length of zero, ending the buffer cleanly
    frame_q = {8'd254, 8'h00, 8'h00, 8'h00, 8'h00};
    send_frame();
    // eight-byte huge length, buffer ends inside the payload
    frame_q = {8'd255, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7E};
    send_frame();
    // buffer ends inside a payload, then inside a length header
    frame_q = {8'h05, 8'h01};
    send_frame();
    frame_q = {8'd253};
    send_frame();

    // random phases over several marker settings
    random_phase(8'd0, 8'd1, 8'd2, 1'b0);
    random_phase(8'd9, 8'd9, 8'd9, 1'b1);
    random_phase(8'd255, 8'd0, 8'd128, 1'b0);
    random_phase(8'd40, 8'd40, 8'd41, 1'b0);
    random_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 1'b0);
    random_phase(8'($urandom_range(0, 20)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 1'b0);
    random_phase(MARKER_TWO_RST, MARKER_FOUR_RST, MARKER_EIGHT_RST, 1'b0);

    wait_idle();
    repeat (IDLE_TAIL) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
